FILE: rtl/qp32_pkg.sv
// Shared types, constants and arithmetic functions for the quaternion pack codec.
// Has no dependencies; every other file of the block except qp32_if.sv refers to it by scoped names.
`default_nettype none

package qp32_pkg;

   localparam int unsigned XY_BITS    = 11;
   localparam int unsigned Z_BITS     = 10;
   localparam int unsigned X_SHIFT    = 21;
   localparam int unsigned Y_SHIFT    = 10;
   localparam int unsigned SQRT_CELLS = 16;

   localparam logic [31:0] ONE_Q2_30 = 32'h4000_0000;
   localparam logic [14:0] W_MAX     = 15'h7FFF;

   typedef enum logic {
      FUNC_COMPRESS   = 1'b0,
      FUNC_DECOMPRESS = 1'b1
   } func_type;

   // One item as it travels down the pipeline.
   typedef struct packed {
      func_type           func;
      logic [31:0]        packed_word;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } item_type;

   // Item plus the radicand, leaving the front stages.
   typedef struct packed {
      item_type    item;
      logic [31:0] rad;
   } prep_type;

   // Item plus the square root recurrence state, passed from cell to cell.
   typedef struct packed {
      item_type    item;
      logic [16:0] rem;
      logic [15:0] root;
      logic [31:0] rad;
   } cell_type;

   // floor((q*1023 + 1024*32768) / 32768); the sum stays inside 0..2^26.
   function automatic logic [10:0] quant_xy(input logic signed [16:0] q);
      logic signed [27:0] t;
      t = (28'(q) <<< 10) - 28'(q) + 28'sh200_0000;
      return t[25:15];
   endfunction

   // floor((q*511 + 512*32768) / 32768); the sum stays inside 0..2^25.
   function automatic logic [9:0] quant_z(input logic signed [16:0] q);
      logic signed [27:0] t;
      t = (28'(q) <<< 9) - 28'(q) + 28'sh100_0000;
      return t[24:15];
   endfunction

   // Apply the sign and saturate a magnitude of at most 32768.
   function automatic logic signed [15:0] sign_sat(input logic neg, input logic [15:0] mag);
      logic signed [16:0] v;
      v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      if (v > 17'sd32767) begin
         v = 17'sd32767;
      end
      return v[15:0];
   endfunction

   // round(32768*(2c-2047)/2047) = 16|d| + round(16|d|/2047), with
   // x/2047 split as x>>11 plus one correction step.
   function automatic logic signed [15:0] deq_xy(input logic [10:0] c);
      logic signed [12:0] d;
      logic [10:0]        mag;
      logic [15:0]        v;
      logic [15:0]        xs;
      logic [4:0]         q0;
      logic [11:0]        r;
      logic [5:0]         q;
      d   = $signed({1'b0, c, 1'b0}) - 13'sd2047;
      mag = d[12] ? 11'(-d) : 11'(d);
      v   = {1'b0, mag, 4'b0000};
      xs  = v + 16'd1023;
      q0  = xs[15:11];
      r   = {1'b0, xs[10:0]} + 12'(q0);
      q   = {1'b0, q0} + 6'(r >= 12'd2047);
      return sign_sat(d[12], v + 16'(q));
   endfunction

   // Same for the 10-bit field: 32|d| + round(32|d|/1023).
   function automatic logic signed [15:0] deq_z(input logic [9:0] c);
      logic signed [11:0] d;
      logic [9:0]         mag;
      logic [15:0]        v;
      logic [15:0]        xs;
      logic [5:0]         q0;
      logic [10:0]        r;
      logic [6:0]         q;
      d   = $signed({1'b0, c, 1'b0}) - 12'sd1023;
      mag = d[11] ? 10'(-d) : 10'(d);
      v   = {1'b0, mag, 5'b00000};
      xs  = v + 16'd511;
      q0  = xs[15:10];
      r   = {1'b0, xs[9:0]} + 11'(q0);
      q   = {1'b0, q0} + 7'(r >= 11'd1023);
      return sign_sat(d[11], v + 16'(q));
   endfunction

endpackage

`default_nettype wire

FILE: rtl/qp32_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Payload types are plain logic vectors declared here, not taken from qp32_pkg.
`default_nettype none

interface qp32_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [15:0] in_w;
   logic signed [15:0] in_x;
   logic signed [15:0] in_y;
   logic signed [15:0] in_z;
   logic [31:0]        in_packed;

   modport source (output valid, func, in_w, in_x, in_y, in_z, in_packed, input ready);
   modport sink   (input valid, func, in_w, in_x, in_y, in_z, in_packed, output ready);
endinterface

interface qp32_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        out_packed;
   logic [14:0]        out_w;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic signed [15:0] out_z;

   modport source (output valid, out_packed, out_w, out_x, out_y, out_z, input ready);
   modport sink   (input valid, out_packed, out_w, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

FILE: rtl/qp32_front.sv
// Front stages: encode or decode, square the components, form the radicand.
// Uses qp32_pkg and qp32_req_if.
`default_nettype none

module qp32_front (
   input  wire              clock,
   input  wire              reset,
   qp32_req_if.sink         req_ch,
   output logic             out_valid,
   input  wire              out_ready,
   output qp32_pkg::prep_type out_data
);

   logic                 valid_s0_ff, valid_s1_ff, valid_s2_ff;
   logic                 ready_s0, ready_s1, ready_s2;
   qp32_pkg::item_type   item_s0_ff, item_s0_in;
   qp32_pkg::item_type   item_s1_ff, item_s2_ff;
   logic [30:0]          sq_x_ff, sq_y_ff, sq_z_ff;
   logic [30:0]          sq_x_in, sq_y_in, sq_z_in;
   logic signed [31:0]   px, py, pz;
   logic [31:0]          sum;
   logic [31:0]          rad_ff, rad_in;
   logic signed [16:0]   qx, qy, qz;

   assign ready_s2     = !valid_s2_ff || out_ready;
   assign ready_s1     = !valid_s1_ff || ready_s2;
   assign ready_s0     = !valid_s0_ff || ready_s1;
   assign req_ch.ready = ready_s0;

   // Stage 0: quantise and pack, or unpack and dequantise.
   always_comb begin
      qx = 17'(req_ch.in_x);
      qy = 17'(req_ch.in_y);
      qz = 17'(req_ch.in_z);
      if (req_ch.in_w[15]) begin
         qx = -qx;
         qy = -qy;
         qz = -qz;
      end
      item_s0_in.func = qp32_pkg::func_type'(req_ch.func);
      if (req_ch.func == qp32_pkg::FUNC_COMPRESS) begin
         item_s0_in.packed_word = {qp32_pkg::quant_xy(qx), qp32_pkg::quant_xy(qy),
                                   qp32_pkg::quant_z(qz)};
         item_s0_in.x = '0;
         item_s0_in.y = '0;
         item_s0_in.z = '0;
      end else begin
         item_s0_in.packed_word = '0;
         item_s0_in.x = qp32_pkg::deq_xy(req_ch.in_packed[31:21]);
         item_s0_in.y = qp32_pkg::deq_xy(req_ch.in_packed[20:10]);
         item_s0_in.z = qp32_pkg::deq_z(req_ch.in_packed[9:0]);
      end
   end

   // Stage 1: squares, each at most 2^30.
   always_comb begin
      px      = item_s0_ff.x * item_s0_ff.x;
      py      = item_s0_ff.y * item_s0_ff.y;
      pz      = item_s0_ff.z * item_s0_ff.z;
      sq_x_in = px[30:0];
      sq_y_in = py[30:0];
      sq_z_in = pz[30:0];
   end

   // Stage 2: |1 - sum| in Q2.30.
   always_comb begin
      sum    = 32'(sq_x_ff) + 32'(sq_y_ff) + 32'(sq_z_ff);
      rad_in = (sum >= qp32_pkg::ONE_Q2_30) ? sum - qp32_pkg::ONE_Q2_30
                                            : qp32_pkg::ONE_Q2_30 - sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s0_ff <= 1'b0;
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
      end else begin
         if (ready_s0) begin
            valid_s0_ff <= req_ch.valid;
         end
         if (ready_s1) begin
            valid_s1_ff <= valid_s0_ff;
         end
         if (ready_s2) begin
            valid_s2_ff <= valid_s1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_s0 && req_ch.valid) begin
         item_s0_ff <= item_s0_in;
      end
      if (ready_s1 && valid_s0_ff) begin
         item_s1_ff <= item_s0_ff;
         sq_x_ff    <= sq_x_in;
         sq_y_ff    <= sq_y_in;
         sq_z_ff    <= sq_z_in;
      end
      if (ready_s2 && valid_s1_ff) begin
         item_s2_ff <= item_s1_ff;
         rad_ff     <= rad_in;
      end
   end

   assign out_valid     = valid_s2_ff;
   assign out_data.item = item_s2_ff;
   assign out_data.rad  = rad_ff;

endmodule

`default_nettype wire

FILE: rtl/qp32_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cell.
// Uses qp32_pkg.
`default_nettype none

module qp32_sqrt_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  wire qp32_pkg::cell_type in_data,
   output logic                    out_valid,
   input  wire                     out_ready,
   output qp32_pkg::cell_type      out_data
);

   logic               valid_ff;
   qp32_pkg::cell_type data_ff, data_in;
   logic [18:0]        shifted;
   logic [17:0]        trial;
   logic               take;
   logic [18:0]        diff;

   assign in_ready = !valid_ff || out_ready;

   // Bring down the next radicand pair and try subtracting 4*root+1.
   always_comb begin
      shifted = {in_data.rem, in_data.rad[31:30]};
      trial   = {in_data.root, 2'b01};
      take    = shifted >= {1'b0, trial};
      diff    = shifted - {1'b0, trial};
      data_in.item = in_data.item;
      data_in.rem  = take ? diff[16:0] : shifted[16:0];
      data_in.root = {in_data.root[14:0], take};
      data_in.rad  = {in_data.rad[29:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: rtl/quaternion_pack_32_core.sv
// Path from request transfer to response transfer: 3 front stages, 16 square root
// cells, 1 output register. Throughput: one transfer per cycle while rsp_ch.ready holds.
// Each stage advances when empty or when its successor advances, so bubbles
// collapse while the response side stalls. Reset is synchronous and active
// high; it empties every stage and the output register. Data registers are not reset.
`default_nettype none

module quaternion_pack_32_core (
   input  wire      clock,
   input  wire      reset,
   qp32_req_if.sink   req_ch,
   qp32_rsp_if.source rsp_ch
);

   localparam int unsigned N = qp32_pkg::SQRT_CELLS;

   // Front end to first cell.
   logic               front_valid;
   qp32_pkg::prep_type front_data;

   // Chain links: index i feeds cell i, index N leaves the last cell.
   logic               link_valid [0:N];
   logic               link_ready [0:N];
   qp32_pkg::cell_type link_data  [0:N];

   // Output register.
   logic               out_valid_ff;
   logic [31:0]        out_packed_ff, out_packed_in;
   logic [14:0]        out_w_ff, out_w_in;
   logic signed [15:0] out_x_ff, out_y_ff, out_z_ff;
   logic               out_ready;
   qp32_pkg::cell_type last;
   logic [16:0]        rounded;

   qp32_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_valid (front_valid),
      .out_ready (link_ready[0]),
      .out_data  (front_data)
   );

   // Start the recurrence with zero root and remainder.
   assign link_valid[0]     = front_valid;
   assign link_data[0].item = front_data.item;
   assign link_data[0].rem  = '0;
   assign link_data[0].root = '0;
   assign link_data[0].rad  = front_data.rad;

   for (genvar i = 0; i < N; i++) begin : g_cell
      qp32_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   assign out_ready     = !out_valid_ff || rsp_ch.ready;
   assign link_ready[N] = out_ready;
   assign last          = link_data[N];

   // Round the root to nearest: step up when the remainder exceeds the root,
   // then saturate to the largest 15-bit value. Drop w on compress.
   always_comb begin
      rounded = {1'b0, last.root} + 17'(last.rem > {1'b0, last.root});
      if (last.item.func == qp32_pkg::FUNC_COMPRESS) begin
         out_w_in = '0;
      end else if (rounded > 17'(qp32_pkg::W_MAX)) begin
         out_w_in = qp32_pkg::W_MAX;
      end else begin
         out_w_in = rounded[14:0];
      end
      out_packed_in = last.item.packed_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= link_valid[N];
      end
   end

   // Hold the result until its transfer; load a new one behind it.
   always_ff @(posedge clock) begin
      if (out_ready && link_valid[N]) begin
         out_packed_ff <= out_packed_in;
         out_w_ff      <= out_w_in;
         out_x_ff      <= last.item.x;
         out_y_ff      <= last.item.y;
         out_z_ff      <= last.item.z;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.out_packed = out_packed_ff;
   assign rsp_ch.out_w      = out_w_ff;
   assign rsp_ch.out_x      = out_x_ff;
   assign rsp_ch.out_y      = out_y_ff;
   assign rsp_ch.out_z      = out_z_ff;

`ifndef SYNTHESIS
   // An empty output register lets every stage advance, so a request is taken.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ch.ready)
      else $error("request side stalled with empty output register");

   // The digit recurrence keeps the remainder at most twice the root.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      link_valid[N] |-> (last.rem <= {last.root, 1'b0}))
      else $error("square root remainder out of range");

   // A response taken with nothing behind it leaves the output register empty.
   a_out_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !link_valid[N]) |=> !out_valid_ff)
      else $error("output register did not drain");

   // A nonzero packed word only comes from compress, which clears the rest.
   a_compress_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.out_packed != '0) |->
         (rsp_ch.out_w == '0 && rsp_ch.out_x == '0 && rsp_ch.out_y == '0 &&
          rsp_ch.out_z == '0))
      else $error("compress response carries decoded fields");
`endif

endmodule

`default_nettype wire
